// ----- design/lec_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the combination enumerator
// no dependencies

package lec_pkg;

    localparam int MAX_CHOOSE_DEF = 8;
    localparam int MAX_ITEMS_DEF  = 16;

    localparam int SET_SIZE_W = 5;
    localparam int CHOOSE_W   = 4;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_ADDR_W = 1;

    localparam int COMB_W   = 32;
    localparam int NIB_W    = 4;
    localparam int COMB_POS = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_SET_SIZE     = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHOOSE_COUNT = 1'd1;

    localparam logic [SET_SIZE_W-1:0] SET_SIZE_RST = 5'd16;
    localparam logic [CHOOSE_W-1:0]   CHOOSE_RST   = 4'd1;

    // per-transfer control broadcast to every cell
    typedef struct packed {
        logic en;    // update the stored indices
        logic load;  // work on the first subset instead of the stored one
        logic adv;   // step to the next subset
    } lec_ctrl_t;

endpackage

// ----- design/lec_cell.sv -----
`timescale 1ns / 1ps
// one position of the subset: stored index, limit test, increment and refill
// depends on lec_pkg

module lec_cell #(
    parameter int POS   = 0,
    parameter int IDX_W = 4,
    parameter int LIM_W = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lec_pkg::lec_ctrl_t       ctrl,
    input  logic [lec_pkg::CHOOSE_W-1:0] k,
    input  logic [LIM_W-1:0]         span,
    input  logic                     sat_in,
    output logic                     sat_out,
    input  logic [IDX_W-1:0]         base_in,
    input  logic                     seen_in,
    output logic [IDX_W-1:0]         base_out,
    output logic                     seen_out,
    output logic [IDX_W-1:0]         eff,
    output logic                     active
);
    import lec_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] first;
    logic [LIM_W-1:0] limit;
    logic             at_max;
    logic             pivot;

    assign active = 32'(k) > 32'(POS);
    assign first  = active ? IDX_W'(POS) : '0;
    assign eff    = ctrl.load ? first : idx_reg;

    assign limit  = span + LIM_W'(POS);
    assign at_max = LIM_W'(eff) >= limit;

    // rightmost active position below its limit, every active one to the right at max
    assign pivot   = active && !at_max && sat_in;
    assign sat_out = sat_in && (!active || at_max);

    // base carries pivot value + 1 - pivot position so a refilled cell adds its own position
    assign base_out = pivot ? (eff + IDX_W'(1) - IDX_W'(POS)) : base_in;
    assign seen_out = pivot || seen_in;

    always_comb
    begin
        idx_next = eff;
        if (ctrl.adv)
        begin
            if (pivot)
                idx_next = eff + IDX_W'(1);
            else if (active && seen_in)
                idx_next = base_in + IDX_W'(POS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (ctrl.en)
            idx_reg <= idx_next;
    end

endmodule

// ----- design/lec_chain.sv -----
`timescale 1ns / 1ps
// row of position cells with the carry and refill links, plus output packing
// depends on lec_pkg and lec_cell

module lec_chain #(
    parameter int MAX_CHOOSE = lec_pkg::MAX_CHOOSE_DEF,
    parameter int IDX_W      = 4,
    parameter int LIM_W      = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lec_pkg::lec_ctrl_t           ctrl,
    input  logic [lec_pkg::CHOOSE_W-1:0] k,
    input  logic [LIM_W-1:0]             span,
    output logic [lec_pkg::COMB_W-1:0]   comb,
    output logic                         none_left
);
    import lec_pkg::*;

    logic             sat  [MAX_CHOOSE+1];
    logic [IDX_W-1:0] base [MAX_CHOOSE+1];
    logic             seen [MAX_CHOOSE+1];
    logic [IDX_W-1:0] eff  [MAX_CHOOSE];
    logic             act  [MAX_CHOOSE];
    logic [NIB_W-1:0] nib  [COMB_POS];

    assign sat[MAX_CHOOSE] = 1'b1;
    assign base[0]         = '0;
    assign seen[0]         = 1'b0;
    assign none_left       = sat[0];

    genvar i;
    generate
        for (i = 0; i < MAX_CHOOSE; i++)
        begin : g_cell
            lec_cell #(
                .POS   (i),
                .IDX_W (IDX_W),
                .LIM_W (LIM_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .k        (k),
                .span     (span),
                .sat_in   (sat[i+1]),
                .sat_out  (sat[i]),
                .base_in  (base[i]),
                .seen_in  (seen[i]),
                .base_out (base[i+1]),
                .seen_out (seen[i+1]),
                .eff      (eff[i]),
                .active   (act[i])
            );
        end

        for (i = 0; i < COMB_POS; i++)
        begin : g_nib
            if (i < MAX_CHOOSE)
            begin : g_used
                logic [IDX_W+NIB_W-1:0] ext;
                assign ext    = {{NIB_W{1'b0}}, eff[i]};
                assign nib[i] = act[i] ? ext[NIB_W-1:0] : '0;
            end
            else
            begin : g_unused
                assign nib[i] = '0;
            end
        end
    endgenerate

    always_comb
    begin
        comb = '0;
        for (int p = 0; p < COMB_POS; p++)
            comb[p*NIB_W +: NIB_W] = nib[p];
    end

endmodule

// ----- design/lexicographic_combination_enumerator.sv -----
`timescale 1ns / 1ps
// Lexicographic k-combination enumerator.
// Input stream: each transfer is one request, s_axis_tdata[0] = restart.
// A restart loads the first subset 0..k-1 and returns an all-zero result;
// any other request returns the current subset and steps to the next one.
// Output stream: tdata holds up to eight 4-bit indices, position 0 lowest;
// tlast marks the final subset, tuser flags exhausted and config error.
// Configuration: cfg_we writes cfg_data to register cfg_addr (0 set size,
// 1 choose count); write only while no result is pending.
// The result is registered and appears in the cycle after the input transfer, and one
// request is taken every cycle while the receiver keeps up: the cell row resolves the carry
// and refill of a step combinationally, rippling through MAX_CHOOSE cells.
// A held result in the output register does not stop a new transfer as
// long as the receiver takes it in the same cycle; if the receiver stalls,
// s_axis_tready drops until the result is taken.
// Reset clears the indices, the loaded and done flags and the output valid
// flag, and sets n=16, k=1; the result payload is not reset. No clearing pass is needed.
// depends on lec_pkg, lec_chain

module lexicographic_combination_enumerator #(
    parameter int MAX_CHOOSE = lec_pkg::MAX_CHOOSE_DEF,
    parameter int MAX_ITEMS  = lec_pkg::MAX_ITEMS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lec_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lec_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [0] restart, rest zero
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [lec_pkg::COMB_W-1:0]     m_axis_tdata,   // [31:0] combination
    output logic                           m_axis_tlast,   // is_last
    output logic [1:0]                     m_axis_tuser    // [0] exhausted, [1] config_error
);
    import lec_pkg::*;

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int LIM_W = $clog2(MAX_ITEMS + MAX_CHOOSE);

    logic [SET_SIZE_W-1:0] set_size_reg;
    logic [CHOOSE_W-1:0]   choose_reg;
    logic                  loaded_reg;
    logic                  done_reg;
    logic                  out_valid_reg;
    logic [COMB_W-1:0]     comb_reg;
    logic                  last_reg;
    logic                  exh_reg;
    logic                  err_reg;

    logic                  accept;
    logic                  restart;
    logic [LIM_W-1:0]      n_sat;
    logic [LIM_W-1:0]      span;
    logic                  cfg_err;
    lec_ctrl_t             ctrl;
    logic [COMB_W-1:0]     comb;
    logic                  none_left;
    logic [COMB_W-1:0]     comb_next;
    logic                  last_next;
    logic                  exh_next;
    logic                  done_next;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign restart       = s_axis_tdata[0];

    assign n_sat   = (32'(set_size_reg) > 32'(MAX_ITEMS)) ? LIM_W'(MAX_ITEMS)
                                                           : LIM_W'(set_size_reg);
    assign cfg_err = (32'(choose_reg) > 32'(MAX_CHOOSE)) ||
                     (32'(choose_reg) > 32'(n_sat));
    assign span    = n_sat - LIM_W'(choose_reg);

    assign ctrl.en   = accept && !cfg_err;
    assign ctrl.load = restart || !loaded_reg;
    assign ctrl.adv  = !restart && !done_reg;

    lec_chain #(
        .MAX_CHOOSE (MAX_CHOOSE),
        .IDX_W      (IDX_W),
        .LIM_W      (LIM_W)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .k         (choose_reg),
        .span      (span),
        .comb      (comb),
        .none_left (none_left)
    );

    always_comb
    begin
        comb_next = '0;
        last_next = 1'b0;
        exh_next  = 1'b0;
        done_next = done_reg;
        if (!cfg_err)
        begin
            if (restart)
                done_next = 1'b0;
            else
            begin
                comb_next = comb;
                if (done_reg)
                begin
                    last_next = 1'b1;
                    exh_next  = 1'b1;
                end
                else
                begin
                    last_next = none_left;
                    done_next = none_left;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg <= SET_SIZE_RST;
            choose_reg   <= CHOOSE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SET_SIZE:     set_size_reg <= cfg_data;
                REG_CHOOSE_COUNT: choose_reg   <= cfg_data[CHOOSE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.en)
            begin
                loaded_reg <= 1'b1;
                done_reg   <= done_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload of the held result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            comb_reg <= comb_next;
            last_reg <= last_next;
            exh_reg  <= exh_next;
            err_reg  <= cfg_err;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = comb_reg;
    assign m_axis_tlast    = last_reg;
    assign m_axis_tuser[0] = exh_reg;
    assign m_axis_tuser[1] = err_reg;

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata == '0 && !m_axis_tlast && !m_axis_tuser[0])
        else $error("config error result carries payload");

    a_exh_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("exhausted result not flagged last");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted request produced no result");

    a_done_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> loaded_reg)
        else $error("done flag set before any load");

endmodule
